// ----- src/triangle_overhang_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the triangle overhang classifier
// Concurrent checks with synchronous active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_OVERHANG_CLASSIFIER_DEFINES_SVH
`define TRIANGLE_OVERHANG_CLASSIFIER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/toc_pkg.sv -----
// ----------------------------------------------------------------------------
// toc_pkg
// Shared constants, register codes and types of the overhang classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package toc_pkg;

    // Default vertex coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // Configuration word and register index widths
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic [CFG_IDX_WIDTH-1:0]    t_cfg_idx;
    typedef logic signed [CFG_WIDTH-1:0] t_cfg_word;

    // Register indexes
    localparam t_cfg_idx CFG_COS_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_DIR_X         = 2'd1;
    localparam t_cfg_idx CFG_DIR_Y         = 2'd2;
    localparam t_cfg_idx CFG_DIR_Z         = 2'd3;

    // Register reset values: cos 30 degrees in Q1.14, direction (0, -1, 0)
    localparam t_cfg_word COS_THRESHOLD_RST = 16'sd14189;
    localparam t_cfg_word DIR_X_RST         = 16'sd0;
    localparam t_cfg_word DIR_Y_RST         = -16'sd1;
    localparam t_cfg_word DIR_Z_RST         = 16'sd0;

    // Operand slice handled per stage of the pipelined multiplier
    localparam int MUL_CHUNK = 16;

    // Scale of the squared dot product: (2^14)^2 from the Q1.14 cosine
    localparam int LHS_SHIFT = 28;

endpackage

`default_nettype wire

// ----- src/toc_if.sv -----
// ----------------------------------------------------------------------------
// toc_in_if / toc_out_if
// Valid/ready channels: triangle vertices in, classification out.
// ----------------------------------------------------------------------------
`default_nettype none

interface toc_in_if #(
    parameter int COORD_WIDTH = toc_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;

    modport source (
        output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        input  ready
    );
    modport sink (
        input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        output ready
    );
endinterface

interface toc_out_if;
    logic valid;
    logic ready;
    logic is_overhang;
    logic degenerate;

    modport source (output valid, is_overhang, degenerate, input ready);
    modport sink (input valid, is_overhang, degenerate, output ready);
endinterface

`default_nettype wire

// ----- src/toc_mul.sv -----
// ----------------------------------------------------------------------------
// toc_mul
// Pipelined unsigned multiplier: one slice of operand b per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module toc_mul #(
    parameter int A_WIDTH = 32,
    parameter int B_WIDTH = 32,
    parameter int CHUNK   = toc_pkg::MUL_CHUNK
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [A_WIDTH-1:0]         i_a,
    input  logic [B_WIDTH-1:0]         i_b,
    output logic [A_WIDTH+B_WIDTH-1:0] o_p
);

    localparam int NCH      = (B_WIDTH + CHUNK - 1) / CHUNK;
    localparam int BP_WIDTH = NCH * CHUNK;
    localparam int P_WIDTH  = A_WIDTH + B_WIDTH;
    localparam int PP_WIDTH = A_WIDTH + CHUNK;

    logic [A_WIDTH-1:0]  r_a   [NCH];
    logic [BP_WIDTH-1:0] r_b   [NCH];
    logic [P_WIDTH-1:0]  r_acc [NCH];
    logic [BP_WIDTH-1:0] w_b_in;

    // Pad b to a whole number of slices
    assign w_b_in = BP_WIDTH'(i_b);

    for (genvar k = 0; k < NCH; k++) begin : g_stage
        logic [A_WIDTH-1:0]  w_a;
        logic [BP_WIDTH-1:0] w_b;
        logic [P_WIDTH-1:0]  w_acc;
        logic [PP_WIDTH-1:0] w_pp;

        if (k == 0) begin : g_first
            assign w_a   = i_a;
            assign w_b   = w_b_in;
            assign w_acc = '0;
        end else begin : g_next
            assign w_a   = r_a[k-1];
            assign w_b   = r_b[k-1];
            assign w_acc = r_acc[k-1];
        end

        // Partial product of a with slice k of b
        assign w_pp = PP_WIDTH'(w_a) * PP_WIDTH'(w_b[k*CHUNK +: CHUNK]);

        // Accumulate the weighted partial product, hold on stall
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= w_a;
                r_b[k]   <= w_b;
                r_acc[k] <= w_acc + (P_WIDTH'(w_pp) << (k * CHUNK));
            end
        end
    end

    assign o_p = r_acc[NCH-1];

endmodule

`default_nettype wire

// ----- src/triangle_overhang_classifier.sv -----
// ----------------------------------------------------------------------------
// triangle_overhang_classifier
// Throughput: one triangle per cycle; stalls only while both output entries are taken.
// Datapath: edge, cross-term, normal and dot stages feed the wide product chain, then the output buffer.
// Reset: clears valid bits and output buffer; registers go to cos 30 deg, dir (0, -1, 0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_overhang_classifier_defines.svh"

module triangle_overhang_classifier #(
    parameter int COORD_WIDTH = toc_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  toc_pkg::t_cfg_idx  i_cfg_idx,
    input  toc_pkg::t_cfg_word i_cfg_data,
    toc_in_if.sink             i_tri,
    toc_out_if.source          o_res
);

    import toc_pkg::*;

    // Datapath widths
    localparam int EW    = COORD_WIDTH + 1;
    localparam int XPW   = 2 * EW;
    localparam int NW    = XPW + 1;
    localparam int MW    = NW - 1;
    localparam int DPW   = CFG_WIDTH + NW;
    localparam int DOTW  = DPW + 2;
    localparam int ADW   = DOTW - 1;
    localparam int N2W   = 2 * MW + 2;
    localparam int C2W   = 2 * CFG_WIDTH - 1;
    localparam int D2W   = 2 * CFG_WIDTH;
    localparam int C2D2W = C2W + D2W;
    localparam int RHSW  = C2D2W + N2W;
    localparam int SQW   = 2 * ADW;
    localparam int LHSW  = SQW + LHS_SHIFT;
    localparam int CMPW  = (LHSW > RHSW) ? LHSW : RHSW;

    // Multiplier latencies and path alignment
    localparam int LSQ   = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LR    = (N2W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LD    = (ADW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int T_R   = 5 + LSQ + LR;
    localparam int T_L   = 6 + LD;
    localparam int T_E   = (T_R > T_L) ? T_R : T_L;
    localparam int SBN   = T_E - 6;
    localparam int DLY_L = T_E - T_L;
    localparam int DLY_R = T_E - T_R;

    typedef struct packed {
        logic vld;
        logic nz;
        logic dpos;
        logic dneg;
    } t_sb;

    typedef struct packed {
        logic is_overhang;
        logic degenerate;
    } t_res;

    // Configuration registers
    t_cfg_word r_cfg_cos;
    t_cfg_word r_cfg_dir [3];

    // Values derived from the configuration
    logic signed [D2W-1:0] w_c_sq;
    logic signed [D2W-1:0] w_d_sq [3];
    logic [C2W-1:0]        r_c2;
    logic [C2W-1:0]        r_dsq [3];
    logic [D2W-1:0]        r_d2;
    logic [C2W-1:0]        r_c2_d;
    logic [C2D2W-1:0]      r_c2d2;
    logic                  w_dz;
    logic                  w_cneg;

    // Pipeline
    logic                          w_adv;
    logic signed [COORD_WIDTH-1:0] w_v0 [3];
    logic signed [COORD_WIDTH-1:0] w_v1 [3];
    logic signed [COORD_WIDTH-1:0] w_v2 [3];
    logic                          r_vld [5];
    logic signed [EW-1:0]          r1_e1 [3];
    logic signed [EW-1:0]          r1_e2 [3];
    logic signed [XPW-1:0]         r2_pa [3];
    logic signed [XPW-1:0]         r2_pb [3];
    logic signed [NW-1:0]          r3_n [3];
    logic [MW-1:0]                 r4_na [3];
    logic signed [DPW-1:0]         r4_dp [3];
    logic                          r4_nz;
    logic signed [DOTW-1:0]        r5_dot;
    logic                          r5_nz;
    logic [ADW-1:0]                r6_adot;
    t_sb                           r6_sb;
    t_sb                           r_sb [SBN];
    logic [2*MW-1:0]               w_nsq [3];
    logic [N2W-1:0]                r_n2;
    logic [RHSW-1:0]               w_rhs;
    logic [RHSW-1:0]               w_rhs_al;
    logic [SQW-1:0]                w_dsq;
    logic [SQW-1:0]                w_dsq_al;

    // Final decision
    t_sb               w_fin;
    logic [CMPW-1:0]   w_lhs;
    logic [CMPW-1:0]   w_rhs_cmp;
    t_res              w_new;

    // Output buffer
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_res       r_q0;
    t_res       r_q1;
    logic       w_full;
    logic       w_push;
    logic       w_pop;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cos    <= COS_THRESHOLD_RST;
            r_cfg_dir[0] <= DIR_X_RST;
            r_cfg_dir[1] <= DIR_Y_RST;
            r_cfg_dir[2] <= DIR_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COS_THRESHOLD: r_cfg_cos    <= i_cfg_data;
                CFG_DIR_X:         r_cfg_dir[0] <= i_cfg_data;
                CFG_DIR_Y:         r_cfg_dir[1] <= i_cfg_data;
                CFG_DIR_Z:         r_cfg_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derive c^2 * |d|^2 from the registers; settles while the block idles
    // ------------------------------------------------------------------
    assign w_c_sq = r_cfg_cos * r_cfg_cos;
    for (genvar g = 0; g < 3; g++) begin : g_dir_sq
        assign w_d_sq[g] = r_cfg_dir[g] * r_cfg_dir[g];
    end

    always_ff @(posedge i_clk) begin
        r_c2 <= C2W'(w_c_sq);
        for (int i = 0; i < 3; i++) begin
            r_dsq[i] <= C2W'(w_d_sq[i]);
        end
        r_d2   <= D2W'(r_dsq[0]) + D2W'(r_dsq[1]) + D2W'(r_dsq[2]);
        r_c2_d <= r_c2;
        r_c2d2 <= C2D2W'(r_c2_d) * C2D2W'(r_d2);
    end

    assign w_dz   = (r_cfg_dir[0] == '0) && (r_cfg_dir[1] == '0) && (r_cfg_dir[2] == '0);
    assign w_cneg = r_cfg_cos[CFG_WIDTH-1];

    // ------------------------------------------------------------------
    // Input side: advance whenever the output buffer has room
    // ------------------------------------------------------------------
    assign w_full      = (r_cnt == 2'd2);
    assign w_adv       = !w_full;
    assign i_tri.ready = w_adv;

    assign w_v0[0] = i_tri.v0_x;
    assign w_v0[1] = i_tri.v0_y;
    assign w_v0[2] = i_tri.v0_z;
    assign w_v1[0] = i_tri.v1_x;
    assign w_v1[1] = i_tri.v1_y;
    assign w_v1[2] = i_tri.v1_z;
    assign w_v2[0] = i_tri.v2_x;
    assign w_v2[1] = i_tri.v2_y;
    assign w_v2[2] = i_tri.v2_z;

    // ------------------------------------------------------------------
    // Stages 1-6: edges, cross terms, normal, |n| and d.n terms, dot, |dot|
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= EW'(w_v1[i]) - EW'(w_v0[i]);
                r1_e2[i] <= EW'(w_v2[i]) - EW'(w_v0[i]);
                r3_n[i]  <= NW'(r2_pa[i]) - NW'(r2_pb[i]);
                r4_na[i] <= MW'(r3_n[i][NW-1] ? -r3_n[i] : r3_n[i]);
                r4_dp[i] <= DPW'(r_cfg_dir[i]) * DPW'(r3_n[i]);
            end
            r2_pa[0] <= XPW'(r1_e1[1]) * XPW'(r1_e2[2]);
            r2_pb[0] <= XPW'(r1_e1[2]) * XPW'(r1_e2[1]);
            r2_pa[1] <= XPW'(r1_e1[2]) * XPW'(r1_e2[0]);
            r2_pb[1] <= XPW'(r1_e1[0]) * XPW'(r1_e2[2]);
            r2_pa[2] <= XPW'(r1_e1[0]) * XPW'(r1_e2[1]);
            r2_pb[2] <= XPW'(r1_e1[1]) * XPW'(r1_e2[0]);
            r4_nz    <= (r3_n[0] == '0) && (r3_n[1] == '0) && (r3_n[2] == '0);
            r5_dot   <= DOTW'(r4_dp[0]) + DOTW'(r4_dp[1]) + DOTW'(r4_dp[2]);
            r5_nz    <= r4_nz;
            r6_adot  <= ADW'(r5_dot[DOTW-1] ? -r5_dot : r5_dot);
            r_n2     <= N2W'(w_nsq[0]) + N2W'(w_nsq[1]) + N2W'(w_nsq[2]);
        end
    end

    // Valid bits and side flags travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '{default: 1'b0};
            r6_sb <= '0;
            r_sb  <= '{default: '0};
        end else if (w_adv) begin
            r_vld[0] <= i_tri.valid;
            for (int i = 1; i < 5; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r6_sb.vld  <= r_vld[4];
            r6_sb.nz   <= r5_nz;
            r6_sb.dpos <= !r5_dot[DOTW-1] && (r5_dot != '0);
            r6_sb.dneg <= r5_dot[DOTW-1];
            r_sb[0]    <= r6_sb;
            for (int i = 1; i < SBN; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Wide products: |n_i|^2, c^2*|d|^2*|n|^2 and dot^2
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 3; g++) begin : g_nsq
        toc_mul #(
            .A_WIDTH (MW),
            .B_WIDTH (MW),
            .CHUNK   (MUL_CHUNK)
        ) u_nsq (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (r4_na[g]),
            .i_b   (r4_na[g]),
            .o_p   (w_nsq[g])
        );
    end

    toc_mul #(
        .A_WIDTH (C2D2W),
        .B_WIDTH (N2W),
        .CHUNK   (MUL_CHUNK)
    ) u_rhs (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_c2d2),
        .i_b   (r_n2),
        .o_p   (w_rhs)
    );

    toc_mul #(
        .A_WIDTH (ADW),
        .B_WIDTH (ADW),
        .CHUNK   (MUL_CHUNK)
    ) u_dsq (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r6_adot),
        .i_b   (r6_adot),
        .o_p   (w_dsq)
    );

    // Align the shorter product path with the longer one
    if (DLY_L > 0) begin : g_dly_l
        logic [SQW-1:0] r_dly [DLY_L];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dly[0] <= w_dsq;
                for (int i = 1; i < DLY_L; i++) begin
                    r_dly[i] <= r_dly[i-1];
                end
            end
        end
        assign w_dsq_al = r_dly[DLY_L-1];
    end else begin : g_nodly_l
        assign w_dsq_al = w_dsq;
    end

    if (DLY_R > 0) begin : g_dly_r
        logic [RHSW-1:0] r_dly [DLY_R];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dly[0] <= w_rhs;
                for (int i = 1; i < DLY_R; i++) begin
                    r_dly[i] <= r_dly[i-1];
                end
            end
        end
        assign w_rhs_al = r_dly[DLY_R-1];
    end else begin : g_nodly_r
        assign w_rhs_al = w_rhs;
    end

    // ------------------------------------------------------------------
    // Decide: 2^28*dot^2 against c^2*|d|^2*|n|^2 by sign case
    // ------------------------------------------------------------------
    assign w_fin     = r_sb[SBN-1];
    assign w_lhs     = CMPW'({w_dsq_al, {LHS_SHIFT{1'b0}}});
    assign w_rhs_cmp = CMPW'(w_rhs_al);

    always_comb begin
        w_new.degenerate  = w_fin.nz || w_dz;
        w_new.is_overhang = 1'b0;
        if (!w_new.degenerate) begin
            if (w_cneg) begin
                w_new.is_overhang = !w_fin.dneg || (w_lhs < w_rhs_cmp);
            end else begin
                w_new.is_overhang = w_fin.dpos && (w_lhs > w_rhs_cmp);
            end
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer
    // ------------------------------------------------------------------
    assign w_push = w_adv && w_fin.vld;
    assign w_pop  = o_res.valid && o_res.ready;
    assign n_cnt  = r_cnt + 2'(w_push) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Head entry takes new data or the second entry; the second fills behind
    always_ff @(posedge i_clk) begin
        if (w_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop))) begin
            r_q0 <= w_new;
        end else if (w_pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
        if (w_push && r_cnt == 2'd1 && !w_pop) begin
            r_q1 <= w_new;
        end
    end

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.is_overhang = r_q0.is_overhang;
    assign o_res.degenerate  = r_q0.degenerate;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TOC_ASSERT_IMPL(a_degen_not_overhang, i_clk, i_rst_n, o_res.valid,
        !(o_res.is_overhang && o_res.degenerate), "degenerate face flagged as overhang")
    `TOC_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push,
        r_cnt == $past(r_cnt) - 2'd1, "buffer count did not drop on pop")
    `TOC_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop,
        r_cnt == $past(r_cnt) + 2'd1, "buffer count did not grow on push")
    `TOC_ASSERT_IMPL(a_accept_while_held, i_clk, i_rst_n,
        o_res.valid && !o_res.ready && r_cnt == 2'd1, i_tri.ready,
        "input stalled while only one result waits")

endmodule

`default_nettype wire
